// ===== rtl/kswrt_pkg.sv =====
// Shared constants and types for the keyed sliding-window rate trip unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kswrt_pkg;

   // Sizing of the key table and of each key's timestamp ring
   localparam int NUM_KEYS   = 64;
   localparam int MAX_EVENTS = 16;

   localparam int KEY_W    = $clog2(NUM_KEYS);
   localparam int SLOT_W   = $clog2(MAX_EVENTS);
   localparam int CNT_W    = $clog2(MAX_EVENTS + 1);
   localparam int STAMP_AW = KEY_W + SLOT_W;
   localparam int STAMP_DEPTH = NUM_KEYS * MAX_EVENTS;

   // Field widths of the ports
   localparam int KEY_ID_W   = 6;
   localparam int TICK_W     = 64;
   localparam int WINDOW_W   = 32;
   localparam int THRESH_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   // Per-key ring descriptor
   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [CNT_W-1:0]  count;
   } meta_type;

   // Write request into the descriptor table
   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] addr;
      meta_type         data;
   } meta_wr_type;

endpackage

// ===== rtl/kswrt_stamp_ram.sv =====
// Timestamp ring storage: one 64-bit entry per key and ring slot.
// Simple dual-port synchronous RAM with a registered read port. Uses kswrt_pkg.
`timescale 1ns / 1ps

module kswrt_stamp_ram
   import kswrt_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [STAMP_AW-1:0] wr_addr,
   input  logic [TICK_W-1:0]   wr_data,
   input  logic                rd_en,
   input  logic [STAMP_AW-1:0] rd_addr,
   output logic [TICK_W-1:0]   rd_data
);

   logic [TICK_W-1:0] stamp_mem [STAMP_DEPTH];
   logic [TICK_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kswrt_meta_ram.sv =====
// Per-key ring descriptor table (oldest slot and held count).
// Synchronous RAM with a valid bit per key so reset reads as an empty ring. Uses kswrt_pkg.
`timescale 1ns / 1ps

module kswrt_meta_ram
   import kswrt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [KEY_W-1:0] rd_addr,
   output meta_type         rd_data,
   input  meta_wr_type      wr
);

   meta_type          meta_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0] valid_ff;
   meta_type          rd_data_ff;
   logic              rd_valid_ff;

   // Descriptor storage
   always_ff @(posedge clock) begin
      if (wr.en) begin
         meta_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= meta_mem[rd_addr];
      end
   end

   // Valid bits: a key never written reads as head 0, count 0
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/keyed_sliding_window_rate_trip_unit.sv =====
// Keyed sliding-window rate trip. Each request beat names a key and a tick; the unit appends
// the tick to that key's ring of timestamps, drops entries older than window_ticks from the
// front, and answers tripped = 1 (clearing the ring) once count_threshold entries remain.
// Items are handled one at a time; the next request is accepted only after the current item
// has delivered its response. An enabled item reads its descriptor, appends the tick, then
// drops d expired entries (0 to 15): every ring entry examined costs one read and one compare
// on the single timestamp RAM read port. A disabled item skips the ring update. Either kind
// waits in the finish state while the previous response has not left the output register.
// One response beat is produced per request beat; a finished response waits in an output
// register while the next request is accepted. Configuration writes are taken
// whenever no item is in progress. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module keyed_sliding_window_rate_trip_unit
   import kswrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KEY_ID_W-1:0]   req_key_id,
   input  logic [TICK_W-1:0]     req_event_tick,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_tripped,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_META   = 3'd1;
   localparam logic [2:0] ST_RD     = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                enable_ff;
   logic [WINDOW_W-1:0] window_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                trip_ff, trip_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_tripped_ff, rsp_tripped_in;

   logic                req_accept;
   logic [KEY_W-1:0]    req_key;
   meta_type            meta_rd;
   meta_wr_type         meta_wr;
   logic                stamp_wr_en;
   logic [SLOT_W-1:0]   stamp_wr_slot;
   logic                stamp_rd_en;
   logic [TICK_W-1:0]   stamp_rd;
   logic [TICK_W-1:0]   age;
   logic                expired;
   logic                out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_key    = KEY_W'(req_key_id % NUM_KEYS);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         window_ff <= '0;
         thresh_ff <= THRESH_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff <= csr_wdata[0];
            CSR_WINDOW:    window_ff <= csr_wdata[WINDOW_W-1:0];
            CSR_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Age of the ring front relative to the current tick, wrapping mod 2^64
   assign age     = tick_ff - stamp_rd;
   assign expired = (age[TICK_W-1:WINDOW_W] != '0) || (age[WINDOW_W-1:0] > window_ff);

   // Sequencer: descriptor read, append, purge loop, decide, deliver; a disabled item goes straight to deliver
   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      tick_in        = tick_ff;
      head_in        = head_ff;
      cnt_in         = cnt_ff;
      trip_in        = trip_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_tripped_in = rsp_tripped_ff;
      stamp_wr_en    = 1'b0;
      stamp_wr_slot  = meta_rd.head;
      stamp_rd_en    = 1'b0;
      meta_wr        = '0;
      meta_wr.addr   = key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in   = req_key;
               tick_in  = req_event_tick;
               trip_in  = 1'b0;
               state_in = enable_ff ? ST_META : ST_FINISH;
            end
         end
         ST_META: begin
            // append; a full ring overwrites its oldest entry
            stamp_wr_en = 1'b1;
            if (meta_rd.count >= CNT_W'(MAX_EVENTS)) begin
               stamp_wr_slot = meta_rd.head;
               head_in       = meta_rd.head + SLOT_W'(1);
               cnt_in        = CNT_W'(MAX_EVENTS);
            end else begin
               stamp_wr_slot = meta_rd.head + meta_rd.count[SLOT_W-1:0];
               head_in       = meta_rd.head;
               cnt_in        = meta_rd.count + CNT_W'(1);
            end
            state_in = ST_RD;
         end
         ST_RD: begin
            stamp_rd_en = 1'b1;
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            if (expired && (cnt_ff != '0)) begin
               head_in  = head_ff + SLOT_W'(1);
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_RD;
            end else begin
               meta_wr.en = 1'b1;
               if (CNT_W'(cnt_ff) >= CNT_W'(thresh_ff)) begin
                  meta_wr.data = '0;
                  trip_in      = 1'b1;
               end else begin
                  meta_wr.data.head  = head_ff;
                  meta_wr.data.count = cnt_ff;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_tripped_in = trip_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the item in progress and the response payload
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      tick_ff        <= tick_in;
      head_ff        <= head_in;
      cnt_ff         <= cnt_in;
      trip_ff        <= trip_in;
      rsp_tripped_ff <= rsp_tripped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tripped = rsp_tripped_ff;

   kswrt_meta_ram u_meta_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_key),
      .rd_data (meta_rd),
      .wr      (meta_wr)
   );

   kswrt_stamp_ram u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr_en),
      .wr_addr ({key_ff, stamp_wr_slot}),
      .wr_data (tick_ff),
      .rd_en   (stamp_rd_en),
      .rd_addr ({key_ff, head_ff}),
      .rd_data (stamp_rd)
   );

`ifndef NO_ASSERTIONS
   // the appended entry is never purged, so the loop always sees a non-empty ring
   a_purge_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (cnt_ff != '0))
      else $error("purge loop reached an empty ring");

   // a stored descriptor never holds more entries than the ring has slots
   a_meta_count: assert property (@(posedge clock) disable iff (reset)
      meta_wr.en |-> (meta_wr.data.count <= CNT_W'(MAX_EVENTS)))
      else $error("descriptor count exceeds ring size");

   // a disabled item touches no ring state and goes straight to delivery
   a_disabled_bypass: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !enable_ff) |=> (state_ff == ST_FINISH))
      else $error("disabled item entered the ring update");

   // a trip is only ever reported while recording is enabled
   a_trip_enabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && trip_ff) |-> enable_ff)
      else $error("trip reported while disabled");

   // a new response is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_FINISH))
      else $error("response register overwritten while stalled");
`endif

endmodule
